// ----- src/rtdc_pkg.sv -----
// shared types and constants for the reverser throttle direction controller
// used by rtdc_level_map and the top level; depends on nothing

package rtdc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 6;
  localparam int SPEED_W  = 8;
  localparam int TIMER_W  = 8;
  localparam int THR_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // lever map: floor(sample * 40 / 1023) - 20
  localparam int ADC_FULL     = 1023;
  localparam int LEVEL_OFFSET = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_DELAY          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_HOLD          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_THRESHOLD = 3'd4;

  localparam logic [TIMER_W-1:0] UPDATE_INTERVAL_RST     = 8'd10;
  localparam logic [TIMER_W-1:0] MODE_DELAY_RST          = 8'd100;
  localparam logic [TIMER_W-1:0] SAMPLE_INTERVAL_RST     = 8'd10;
  localparam logic [TIMER_W-1:0] RELAY_HOLD_RST          = 8'd30;
  localparam logic [THR_W-1:0]   DIRECTION_THRESHOLD_RST = 5'd10;

  typedef enum logic [1:0] {
    MODE_STAT  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2
  } dir_t;

endpackage

// ----- src/rtdc_level_map.sv -----
// maps a 10-bit lever sample to a signed level in -20..20
// depends on rtdc_pkg

module rtdc_level_map
  import rtdc_pkg::*;
(
  input  logic [SAMPLE_W-1:0]       sample,
  output logic signed [LEVEL_W-1:0] level
);

  logic [15:0] prod;
  logic [5:0]  hi;
  logic [9:0]  lo;
  logic [10:0] fold;
  logic [5:0]  quot;
  logic signed [LEVEL_W:0] lv_wide;

  // x = hi*1024 + lo = hi*1023 + (hi + lo), and hi + lo < 2*1023
  always_comb begin
    prod = ({6'b0, sample} << 5) + ({6'b0, sample} << 3);
    hi   = prod[15:10];
    lo   = prod[9:0];
    fold = {5'b0, hi} + {1'b0, lo};
    quot = hi + ((fold >= 11'(ADC_FULL)) ? 6'd1 : 6'd0);
    lv_wide = $signed({1'b0, quot}) - 7'(LEVEL_OFFSET);
    level = lv_wide[LEVEL_W-1:0];
  end

endmodule

// ----- src/reverser_throttle_direction_controller.sv -----
// Reverser lever to throttle direction controller. One request per 10 ms tick carries the
// lever sample and yields one result: throttle speed, a speed-step strobe, the relay drive and
// the mode code. An accepted request is registered, then a single combinational pass updates
// the mode machine and loads the result register, so a request can be taken every cycle while
// m_axis_tready does not stall the output; its result passes from the input register to the
// result register. Registers are written via cfg_we.
// depends on rtdc_pkg and rtdc_level_map

module reverser_throttle_direction_controller
  import rtdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tdata: reverser_sample[9:0], zeros above
  input  logic [15:0]           s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: throttle_speed[7:0], speed_changed[8], relay_on[9], mode_code[11:10], zeros above
  output logic [15:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TIMER_W-1:0] update_interval, mode_delay, sample_interval, relay_hold;
  logic [THR_W-1:0]   direction_threshold;

  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;
  logic                advance;
  logic                step;

  mode_t                     mode;
  logic                      entering;
  logic [TIMER_W-1:0]        pause_timer, ramp_timer;
  logic signed [SPEED_W-1:0] speed;
  logic signed [LEVEL_W-1:0] held_level;
  dir_t                      picked_direction, last_direction;
  logic                      paused, relay;

  mode_t                     mode_next;
  logic                      entering_next;
  logic [TIMER_W-1:0]        pause_timer_next, ramp_timer_next;
  logic signed [SPEED_W-1:0] speed_next;
  logic signed [LEVEL_W-1:0] held_level_next;
  dir_t                      picked_direction_next, last_direction_next;
  logic                      paused_next, relay_next, changed_next;

  logic signed [LEVEL_W-1:0] level;
  logic signed [SPEED_W-1:0] level_ext, target;
  logic signed [LEVEL_W:0]   held_ext, thr_ext;
  logic                      leave;

  rtdc_level_map u_map (
    .sample (in_sample),
    .level  (level)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval     <= UPDATE_INTERVAL_RST;
      mode_delay          <= MODE_DELAY_RST;
      sample_interval     <= SAMPLE_INTERVAL_RST;
      relay_hold          <= RELAY_HOLD_RST;
      direction_threshold <= DIRECTION_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPDATE_INTERVAL:     update_interval     <= cfg_data;
        CFG_MODE_DELAY:          mode_delay          <= cfg_data;
        CFG_SAMPLE_INTERVAL:     sample_interval     <= cfg_data;
        CFG_RELAY_HOLD:          relay_hold          <= cfg_data;
        CFG_DIRECTION_THRESHOLD: direction_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  // one tick of the mode machine
  always_comb begin
    mode_next             = mode;
    entering_next         = entering;
    pause_timer_next      = pause_timer;
    ramp_timer_next       = ramp_timer;
    speed_next            = speed;
    held_level_next       = held_level;
    picked_direction_next = picked_direction;
    last_direction_next   = last_direction;
    paused_next           = paused;
    relay_next            = relay;
    changed_next          = 1'b0;
    leave                 = 1'b0;
    level_ext             = {{(SPEED_W-LEVEL_W){level[LEVEL_W-1]}}, level};
    target                = (level_ext <<< 2) + level_ext;
    thr_ext               = $signed({2'b0, direction_threshold});
    held_ext              = '0;

    if (pause_timer_next != '0) pause_timer_next = pause_timer_next - 1'b1;
    if (ramp_timer_next != '0)  ramp_timer_next  = ramp_timer_next - 1'b1;

    if (paused) begin
      if (pause_timer_next == '0) paused_next = 1'b0;
    end else if (mode == MODE_STAT) begin
      if (entering) begin
        picked_direction_next = DIR_NEUTRAL;
        entering_next         = 1'b0;
      end
      if (pause_timer_next == '0) begin
        pause_timer_next = sample_interval;
        held_level_next  = level;
      end
      held_ext = {held_level_next[LEVEL_W-1], held_level_next};
      if (held_ext < -thr_ext) picked_direction_next = DIR_LEFT;
      if (held_ext > thr_ext)  picked_direction_next = DIR_RIGHT;
      if (picked_direction_next != DIR_NEUTRAL) begin
        if (picked_direction_next != last_direction) relay_next = 1'b1;
        if (ramp_timer_next == '0) leave = 1'b1;
      end else begin
        ramp_timer_next = relay_hold;
      end
      if (leave) begin
        relay_next          = 1'b0;
        last_direction_next = picked_direction_next;
        entering_next       = 1'b1;
        if (mode_delay != '0) begin
          paused_next      = 1'b1;
          pause_timer_next = mode_delay;
        end
        mode_next = (picked_direction_next == DIR_LEFT) ? MODE_LEFT : MODE_RIGHT;
      end
    end else begin
      if (entering) begin
        ramp_timer_next = '0;
        entering_next   = 1'b0;
      end
      if (ramp_timer_next == '0) begin
        ramp_timer_next = update_interval;
        if (target < speed)      speed_next = speed - 8'sd1;
        else if (target > speed) speed_next = speed + 8'sd1;
        changed_next = (speed_next != speed);
      end
      if (speed_next == '0) begin
        entering_next = 1'b1;
        if (mode_delay != '0) begin
          paused_next      = 1'b1;
          pause_timer_next = mode_delay;
        end
        mode_next = MODE_STAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_STAT;
      entering         <= 1'b1;
      pause_timer      <= '0;
      ramp_timer       <= '0;
      speed            <= '0;
      held_level       <= '0;
      picked_direction <= DIR_NEUTRAL;
      last_direction   <= DIR_LEFT;
      paused           <= 1'b0;
      relay            <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (step) begin
        mode             <= mode_next;
        entering         <= entering_next;
        pause_timer      <= pause_timer_next;
        ramp_timer       <= ramp_timer_next;
        speed            <= speed_next;
        held_level       <= held_level_next;
        picked_direction <= picked_direction_next;
        last_direction   <= last_direction_next;
        paused           <= paused_next;
        relay            <= relay_next;
        m_axis_tvalid    <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid    <= 1'b0;
      end
    end
    if (step) begin
      m_axis_tdata <= {4'b0, mode_next, relay_next, changed_next, speed_next};
    end
  end

`ifndef SYNTHESIS
  // the relay only pulses while choosing a direction
  assert property (@(posedge clk) disable iff (rst) (mode != MODE_STAT) |-> !relay)
    else $error("relay energised while moving");

  // moving always ends at standstill, so stationary means zero speed
  assert property (@(posedge clk) disable iff (rst) (mode == MODE_STAT) |-> (speed == '0))
    else $error("nonzero speed while stationary");

  assert property (@(posedge clk) disable iff (rst)
                   (speed <= 8'sd100) && (speed >= -8'sd100))
    else $error("speed out of range");

  // a pause is only kept while its timer still runs
  assert property (@(posedge clk) disable iff (rst) paused |-> (pause_timer != '0))
    else $error("pause held with expired timer");
`endif

endmodule
